>>> rtl/think_tag_stream_filter_macros.svh
// assertion macros shared by the think-tag filter rtl
// expects aclk, and for TTSF_ASSERT also aresetn, in the scope of every use
`ifndef THINK_TAG_STREAM_FILTER_MACROS_SVH
`define THINK_TAG_STREAM_FILTER_MACROS_SVH

// checked on every rising edge outside reset
`define TTSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge, reset included
`define TTSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/ttsf_pkg.sv
// types, request codes and tag characters of the think-tag stream filter
// used by ttsf_match, ttsf_emit and think_tag_stream_filter; no dependencies
package ttsf_pkg;

    localparam logic [1:0] REQ_TEXT    = 2'd0;
    localparam logic [1:0] REQ_FINISH  = 2'd1;
    localparam logic [1:0] REQ_DISCARD = 2'd2;

    localparam logic [3:0] OPEN_LEN  = 4'd7;
    localparam logic [3:0] CLOSE_LEN = 4'd8;

    localparam logic [7:0] CHR_LT    = 8'h3c;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_LF    = 8'h0a;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       end_of_response;
    } out_t;

    // what one input beat must emit: replayed open-tag prefix, then an
    // optional pass-through byte; fin marks a finish request
    typedef struct packed {
        logic [2:0] rep_cnt;
        logic       tail_valid;
        logic [7:0] tail_byte;
        logic       fin;
    } desc_t;

    // "<think>"
    function automatic logic [7:0] open_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3c;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h68;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h6e;
            3'd5:    c = 8'h6b;
            3'd6:    c = 8'h3e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "</think>"
    function automatic logic [7:0] close_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3c;
            3'd1:    c = 8'h2f;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h68;
            3'd4:    c = 8'h69;
            3'd5:    c = 8'h6e;
            3'd6:    c = 8'h6b;
            3'd7:    c = 8'h3e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/ttsf_match.sv
// tag matcher: block/match/skip state and the emit descriptor of each beat
// depends on ttsf_pkg and think_tag_stream_filter_macros.svh
`include "think_tag_stream_filter_macros.svh"

module ttsf_match (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ttsf_pkg::in_t    s_payload,
    output logic             d_valid,
    input  logic             d_ready,
    output ttsf_pkg::desc_t  d_desc
);

    logic       inside_reg, inside_next;
    logic [2:0] match_reg, match_next;
    logic       skip_reg, skip_next;

    logic       s_fire;
    logic [2:0] m_eff;
    logic [7:0] pat_char;
    logic [3:0] tag_len;
    logic [3:0] m_inc;
    logic       is_ws;
    logic [7:0] b;

    assign s_ready = d_ready;
    assign s_fire  = s_valid && s_ready;
    assign b       = s_payload.data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            match_reg  <= 3'd0;
            skip_reg   <= 1'b0;
        end else begin
            inside_reg <= inside_next;
            match_reg  <= match_next;
            skip_reg   <= skip_next;
        end
    end

    always_comb begin
        // a full-length count outside a block is treated as empty
        m_eff    = (!inside_reg && match_reg == 3'd7) ? 3'd0 : match_reg;
        pat_char = inside_reg ? ttsf_pkg::close_char(m_eff) : ttsf_pkg::open_char(m_eff);
        tag_len  = inside_reg ? ttsf_pkg::CLOSE_LEN : ttsf_pkg::OPEN_LEN;
        m_inc    = {1'b0, m_eff} + 4'd1;
        is_ws    = (b == ttsf_pkg::CHR_SPACE) || (b == ttsf_pkg::CHR_CR) ||
                   (b == ttsf_pkg::CHR_LF);

        inside_next = inside_reg;
        match_next  = match_reg;
        skip_next   = skip_reg;
        d_desc      = '0;
        d_valid     = 1'b0;

        if (s_fire) begin
            case (s_payload.req_type)
                ttsf_pkg::REQ_DISCARD: begin
                    inside_next = 1'b0;
                    match_next  = 3'd0;
                    skip_next   = 1'b0;
                end
                ttsf_pkg::REQ_FINISH: begin
                    d_desc.rep_cnt = inside_reg ? 3'd0 : m_eff;
                    d_desc.fin     = 1'b1;
                    d_valid        = 1'b1;
                    inside_next    = 1'b0;
                    match_next     = 3'd0;
                    skip_next      = 1'b0;
                end
                ttsf_pkg::REQ_TEXT: begin
                    if (!(skip_reg && is_ws)) begin
                        skip_next = 1'b0;
                        if (b == pat_char) begin
                            if (m_inc == tag_len) begin
                                inside_next = !inside_reg;
                                match_next  = 3'd0;
                                if (inside_reg) begin
                                    skip_next = 1'b1;
                                end
                            end else begin
                                match_next = m_inc[2:0];
                            end
                        end else begin
                            // held prefix is replayed outside, dropped inside
                            d_desc.rep_cnt = inside_reg ? 3'd0 : m_eff;
                            if (b == ttsf_pkg::CHR_LT) begin
                                match_next = 3'd1;
                            end else begin
                                match_next        = 3'd0;
                                d_desc.tail_valid = !inside_reg;
                                d_desc.tail_byte  = b;
                            end
                            d_valid = (d_desc.rep_cnt != 3'd0) || d_desc.tail_valid;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `TTSF_ASSERT(a_open_count, !inside_reg |-> match_reg != 3'd7, "open-tag count reached tag length")
    `TTSF_ASSERT(a_skip_outside, skip_reg |-> !inside_reg, "whitespace skip active inside a block")
    `TTSF_ASSERT(a_finish_clears, s_fire && s_payload.req_type == ttsf_pkg::REQ_FINISH |=> !inside_reg && match_reg == 3'd0 && !skip_reg, "state not cleared after finish")

endmodule

>>> rtl/ttsf_emit.sv
// result sequencer: expands a descriptor into output beats, one per cycle while the output is not stalled
// depends on ttsf_pkg and think_tag_stream_filter_macros.svh
`include "think_tag_stream_filter_macros.svh"

module ttsf_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             d_valid,
    output logic             d_ready,
    input  ttsf_pkg::desc_t  d_desc,
    output logic             m_valid,
    input  logic             m_ready,
    output ttsf_pkg::out_t   m_payload
);

    logic            cur_valid_reg, cur_valid_next;
    ttsf_pkg::desc_t cur_reg;
    logic [2:0]      idx_reg, idx_next;
    logic            m_valid_reg;
    ttsf_pkg::out_t  m_data_reg, m_data_next;

    logic       out_load;
    logic [2:0] sum_cnt;
    logic [2:0] total;
    logic       beat_last;
    logic       emit;
    logic       in_rep;

    assign out_load  = !m_valid_reg || m_ready;
    assign sum_cnt   = cur_reg.rep_cnt + {2'b00, cur_reg.tail_valid};
    // a finish with nothing held still sends one empty beat
    assign total     = (sum_cnt == 3'd0) ? 3'd1 : sum_cnt;
    assign beat_last = (idx_reg == total - 3'd1);
    assign emit      = cur_valid_reg && out_load;
    assign d_ready   = !cur_valid_reg || (emit && beat_last);
    assign in_rep    = idx_reg < cur_reg.rep_cnt;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (d_valid && d_ready) begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end else if (emit) begin
            if (beat_last) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end

        m_data_next.out_byte        = in_rep ? ttsf_pkg::open_char(idx_reg) :
                                      (cur_reg.tail_valid ? cur_reg.tail_byte : 8'h00);
        m_data_next.byte_valid      = in_rep || cur_reg.tail_valid;
        m_data_next.last            = beat_last;
        m_data_next.end_of_response = beat_last && cur_reg.fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (out_load) begin
                m_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_valid && d_ready) begin
            cur_reg <= d_desc;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    `TTSF_ASSERT(a_idx_range, cur_valid_reg |-> idx_reg < total, "beat index past descriptor end")
    `TTSF_ASSERT(a_eor_last, m_valid_reg && m_data_reg.end_of_response |-> m_data_reg.last, "end of response without last")
    `TTSF_ASSERT(a_empty_beat, m_valid_reg && !m_data_reg.byte_valid |-> m_data_reg.end_of_response && m_data_reg.out_byte == 8'h00, "empty beat outside finish")

endmodule

>>> rtl/think_tag_stream_filter.sv
// think-tag stream filter top level: matcher feeding the result sequencer
// depends on ttsf_pkg, ttsf_match and ttsf_emit
//
//  channel  ports                          beat
//  s_       s_valid s_ready s_payload      req_type, data_byte
//  m_       m_valid m_ready m_payload      out_byte, byte_valid, last, end_of_response
//
// an accepted beat's descriptor is registered in the sequencer; its first result then passes to the output register
// a beat with n results (1 to 7) holds s_ready low until its last result is issued; a beat with none passes freely
// plain text passes at one byte per cycle while the output is not stalled; only tag-prefix replays take longer
// aresetn is synchronous and clears tag state, sequencer and output valid
// m_ready low holds the output register and, once the sequencer is full, s_ready

module think_tag_stream_filter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ttsf_pkg::in_t   s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output ttsf_pkg::out_t  m_payload
);

    logic            d_valid;
    logic            d_ready;
    ttsf_pkg::desc_t d_desc;

    ttsf_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .d_valid   (d_valid),
        .d_ready   (d_ready),
        .d_desc    (d_desc)
    );

    ttsf_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .d_valid   (d_valid),
        .d_ready   (d_ready),
        .d_desc    (d_desc),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> tb/tb_think_tag_stream_filter.sv
// self-checking testbench for think_tag_stream_filter: directed tag cases,
// a long output stall and a random tag-heavy byte stream
// depends on ttsf_pkg and the think_tag_stream_filter rtl
`timescale 1ns / 100ps

module tb_think_tag_stream_filter;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [0:7][7:0] OPEN_TAG  = {"<think>", 8'h00};
    localparam logic [0:7][7:0] CLOSE_TAG = "</think>";

    localparam int RANDOM_ITEMS   = 360;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    ttsf_pkg::in_t  s_payload;
    logic           m_valid;
    logic           m_ready;
    ttsf_pkg::out_t m_payload;

    // filter state as predicted from accepted beats
    logic       in_block;
    logic [2:0] held_len;
    logic       ws_skip;

    ttsf_pkg::out_t filt_q[$];
    ttsf_pkg::out_t want;

    int unsigned tx_gap_max;
    int unsigned rx_gap_max;
    logic        long_hold_req;

    int unsigned items_sent;
    int unsigned beats_in;
    int unsigned finish_cnt;
    int unsigned discard_cnt;
    int unsigned results_checked;
    int unsigned blocks_closed;
    int unsigned stall_cycles;
    int unsigned quiet_cycles;
    int unsigned errors;

    think_tag_stream_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic ttsf_pkg::out_t text_beat(input logic [7:0] b);
        ttsf_pkg::out_t r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // next state of the filter and the results one accepted beat causes
    function automatic void predict_filter(input ttsf_pkg::in_t beat);
        ttsf_pkg::out_t res [0:7];
        int             n;
        int             k;
        int             tag_len;
        logic [2:0]     held;
        logic [7:0]     tag_ch;
        logic           is_ws;
        n       = 0;
        tag_len = in_block ? 8 : 7;
        held    = (int'(held_len) >= tag_len) ? 3'd0 : held_len;
        is_ws   = (beat.data_byte == ttsf_pkg::CHR_SPACE) ||
                  (beat.data_byte == ttsf_pkg::CHR_CR) ||
                  (beat.data_byte == ttsf_pkg::CHR_LF);
        case (beat.req_type)
            ttsf_pkg::REQ_DISCARD: begin
                in_block = 1'b0;
                held_len = 3'd0;
                ws_skip  = 1'b0;
            end
            ttsf_pkg::REQ_FINISH: begin
                if (!in_block) begin
                    for (k = 0; k < int'(held); k++) begin
                        res[n] = text_beat(OPEN_TAG[k]);
                        n++;
                    end
                end
                if (n == 0) begin
                    res[0] = '0;
                    n = 1;
                end
                res[n-1].last            = 1'b1;
                res[n-1].end_of_response = 1'b1;
                in_block = 1'b0;
                held_len = 3'd0;
                ws_skip  = 1'b0;
            end
            ttsf_pkg::REQ_TEXT: begin
                if (!(ws_skip && is_ws)) begin
                    ws_skip = 1'b0;
                    tag_ch  = in_block ? CLOSE_TAG[held] : OPEN_TAG[held];
                    if (beat.data_byte == tag_ch) begin
                        if (int'(held) + 1 == tag_len) begin
                            in_block = !in_block;
                            held_len = 3'd0;
                            if (!in_block) begin
                                ws_skip = 1'b1;
                                blocks_closed++;
                            end
                        end else begin
                            held_len = held + 3'd1;
                        end
                    end else begin
                        // mismatch: replay the held open-tag prefix outside a block
                        if (!in_block) begin
                            for (k = 0; k < int'(held); k++) begin
                                res[n] = text_beat(OPEN_TAG[k]);
                                n++;
                            end
                        end
                        if (beat.data_byte == ttsf_pkg::CHR_LT) begin
                            held_len = 3'd1;
                        end else begin
                            if (!in_block) begin
                                res[n] = text_beat(beat.data_byte);
                                n++;
                            end
                            held_len = 3'd0;
                        end
                        if (n > 0)
                            res[n-1].last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        for (k = 0; k < n; k++)
            filt_q.insert(filt_q.size(), res[k]);
    endfunction

    // input monitor and result checker, sampled at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_filter(s_payload);
                beats_in++;
                if (s_payload.req_type == ttsf_pkg::REQ_FINISH)
                    finish_cnt++;
                if (s_payload.req_type == ttsf_pkg::REQ_DISCARD)
                    discard_cnt++;
            end
            if (s_valid && !s_ready)
                stall_cycles++;
            if (m_valid && m_ready) begin
                if (filt_q.size() == 0) begin
                    $error("result beat with nothing expected: byte %0h valid %0b last %0b eor %0b",
                           m_payload.out_byte, m_payload.byte_valid, m_payload.last,
                           m_payload.end_of_response);
                    errors++;
                end else begin
                    want = filt_q.pop_front();
                    results_checked++;
                    if (m_payload.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte,
                               m_payload.out_byte);
                        errors++;
                    end
                    if (m_payload.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                               m_payload.byte_valid);
                        errors++;
                    end
                    if (m_payload.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_payload.last);
                        errors++;
                    end
                    if (m_payload.end_of_response !== want.end_of_response) begin
                        $error("end_of_response: expected %0b, got %0b",
                               want.end_of_response, m_payload.end_of_response);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, filt_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls per beat, plus one long hold on request
    initial begin : result_sink
        int unsigned pause;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end
            pause = $urandom_range(0, rx_gap_max);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !long_hold_req);
        end
    end

    task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
        int unsigned   gap;
        ttsf_pkg::in_t beat;
        gap = $urandom_range(0, tx_gap_max);
        beat.req_type  = req;
        beat.data_byte = b;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_beat(ttsf_pkg::REQ_TEXT, txt[i]);
    endtask

    // drops s_valid and lets the monitor predict the last accepted beat before waiting for an empty queue
    task automatic settle_input();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (filt_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        tx_gap_max = 7;
        rx_gap_max = 7;
        send_beat(ttsf_pkg::REQ_TEXT, 8'h00);
        send_beat(ttsf_pkg::REQ_TEXT, 8'hff);
        send_text("<tx");       // replay of a held prefix, then the breaking byte
        send_text("<th<");      // mismatch on '<' starts a new prefix
        send_beat(ttsf_pkg::REQ_FINISH, 8'h00);
        send_text("<think>");
        send_text("</t");
        send_beat(ttsf_pkg::REQ_FINISH, 8'hff);  // partial close tag is dropped
        send_text("<");
        send_beat(REQ_UNUSED, 8'h5a);
        send_beat(ttsf_pkg::REQ_DISCARD, 8'ha5);
        send_text("x");
        settle_input();
    endtask

    // output held off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int k;
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_beat(ttsf_pkg::REQ_DISCARD, 8'h00);
        long_hold_req = 1'b1;
        for (k = 0; k < 60; k++)
            send_beat(ttsf_pkg::REQ_TEXT, 8'($urandom_range(8'h61, 8'h7a)));
        settle_input();
    endtask

    task automatic test_random_stream();
        int unsigned start;
        int unsigned burst;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        logic        use_close;
        logic [7:0]  b;
        string       vocab;
        vocab = "<>/think";
        start = items_sent;
        burst = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (burst == 0) begin
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                burst = 40;
            end
            burst--;
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    send_beat(ttsf_pkg::REQ_TEXT, 8'($urandom_range(0, 255)));
            end else if (pick < 36) begin
                send_text("<think>");
            end else if (pick < 50) begin
                send_text("</think>");
            end else if (pick < 66) begin
                // partial tag broken by a random byte, '<' or whitespace
                use_close = 1'($urandom_range(0, 1));
                len = $urandom_range(1, use_close ? 7 : 6);
                for (k = 0; k < len; k++)
                    send_beat(ttsf_pkg::REQ_TEXT, use_close ? CLOSE_TAG[k] : OPEN_TAG[k]);
                case ($urandom_range(0, 2))
                    0:       b = ttsf_pkg::CHR_LT;
                    1:       b = ttsf_pkg::CHR_SPACE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_beat(ttsf_pkg::REQ_TEXT, b);
            end else if (pick < 76) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 2))
                        0:       b = ttsf_pkg::CHR_SPACE;
                        1:       b = ttsf_pkg::CHR_CR;
                        default: b = ttsf_pkg::CHR_LF;
                    endcase
                    send_beat(ttsf_pkg::REQ_TEXT, b);
                end
            end else if (pick < 86) begin
                send_beat(ttsf_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
            end else if (pick < 91) begin
                send_beat(ttsf_pkg::REQ_DISCARD, 8'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                send_beat(REQ_UNUSED, 8'($urandom_range(0, 255)));
            end else begin
                // near misses built from the tag characters
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    send_beat(ttsf_pkg::REQ_TEXT, vocab[$urandom_range(0, vocab.len() - 1)]);
            end
        end
        settle_input();
    endtask

    initial begin
        in_block        = 1'b0;
        held_len        = 3'd0;
        ws_skip         = 1'b0;
        long_hold_req   = 1'b0;
        tx_gap_max      = 0;
        rx_gap_max      = 0;
        items_sent      = 0;
        beats_in        = 0;
        finish_cnt      = 0;
        discard_cnt     = 0;
        results_checked = 0;
        blocks_closed   = 0;
        stall_cycles    = 0;
        quiet_cycles    = 0;
        errors          = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_stream();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d input beats (%0d finish, %0d discard) and %0d think blocks;",
                 beats_in, finish_cnt, discard_cnt, blocks_closed);
        $display("checked %0d result beats, input stalled for %0d cycles, %0d mismatches",
                 results_checked, stall_cycles, errors);
        if (errors == 0 && filt_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ttsf_pkg.sv
rtl/ttsf_match.sv
rtl/ttsf_emit.sv
rtl/think_tag_stream_filter.sv
tb/tb_think_tag_stream_filter.sv
